// File: hdl/yed_pkg.sv
// yed_pkg: shared types and constants of the yawn episode detector.
// No dependencies; imported by every module under hdl/.
`default_nettype none

package yed_pkg;

  localparam int MIN_W   = 8;   // yawn_min_seconds width
  localparam int RATE_W  = 9;   // rate_threshold width, unsigned Q1.8
  localparam int FRAC_W  = 8;   // fraction bits of rate_threshold
  localparam int TIME_W  = 32;  // timestamp width
  localparam int SHOWN_W = 16;  // width of the reported yawn count
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [MIN_W-1:0]  MIN_RESET  = 8'd2;
  localparam logic [RATE_W-1:0] RATE_RESET = 9'd51;

  // close-run counter saturates here
  localparam logic [1:0] CLOSE_RUN_MAX = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_YAWN_MIN_SECONDS = 2'd0,
    CFG_RATE_THRESHOLD   = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [MIN_W-1:0]  yawn_min_seconds;
    logic [RATE_W-1:0] rate_threshold;
  } yed_cfg_t;

  typedef struct packed {
    logic               yawn_event;
    logic               fatigue;
    logic               window_done;
    logic [SHOWN_W-1:0] yawns_in_window;
  } yed_res_t;

endpackage

`default_nettype wire

// File: hdl/yed_cfg.sv
// yed_cfg: configuration register file (yawn_min_seconds, rate_threshold).
// Depends on yed_pkg.
`default_nettype none

module yed_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [yed_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [yed_pkg::CFG_DATA_W-1:0]   cfg_data,
  output yed_pkg::yed_cfg_t                     cfg_out
);
  import yed_pkg::*;

  logic [MIN_W-1:0]  min_sec_r;
  logic [RATE_W-1:0] rate_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sec_r <= MIN_RESET;
      rate_r    <= RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_YAWN_MIN_SECONDS: min_sec_r <= cfg_data[MIN_W-1:0];
        CFG_RATE_THRESHOLD:   rate_r    <= cfg_data[RATE_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  assign cfg_out.yawn_min_seconds = min_sec_r;
  assign cfg_out.rate_threshold   = rate_r;

endmodule

`default_nettype wire

// File: hdl/yed_tracker.sv
// yed_tracker: open-run tracker, window counters and fatigue compare.
// One frame per fire; result is combinational from the input register.
// Depends on yed_pkg.
`default_nettype none

module yed_tracker #(
  parameter int COUNT_BITS       = 16,
  parameter int END_CLOSE_FRAMES = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          fire,
  input  wire logic                          mouth_open,
  input  wire logic [yed_pkg::TIME_W-1:0]    now_seconds,
  input  wire logic                          window_end,
  input  wire yed_pkg::yed_cfg_t             cfg,
  output yed_pkg::yed_res_t                  res
);
  import yed_pkg::*;

  localparam int CW = COUNT_BITS;
  localparam int PW = CW + RATE_W;  // compare width, covers CW+FRAC_W too
  localparam logic [1:0]    END_CNT = 2'(END_CLOSE_FRAMES);
  localparam logic [CW-1:0] CNT_MAX = '1;

  logic             last_open_r, last_open_nxt;
  logic [1:0]       close_run_r, close_run_nxt;
  logic [CW-1:0]    open_run_r, open_run_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [CW-1:0]    yawn_frames_r, yawn_frames_nxt;
  logic [CW-1:0]    yawn_total_r, yawn_total_nxt;
  logic [CW-1:0]    win_frames_r, win_frames_nxt;

  logic [CW-1:0]    wf_inc;
  logic [1:0]       cr_inc;
  logic [TIME_W-1:0] dur;
  logic [CW:0]      yf_sum;
  logic [PW-1:0]    lhs, rhs;
  logic             yawn;
  logic             fatigue;
  logic [CW-1:0]    shown_cnt;
  logic [SHOWN_W-1:0] shown;

  always_comb begin
    last_open_nxt   = last_open_r;
    close_run_nxt   = close_run_r;
    open_run_nxt    = open_run_r;
    start_nxt       = start_r;
    yawn_frames_nxt = yawn_frames_r;
    yawn_total_nxt  = yawn_total_r;
    yawn            = 1'b0;
    fatigue         = 1'b0;
    lhs             = '0;
    rhs             = '0;

    wf_inc = (win_frames_r == CNT_MAX) ? CNT_MAX : win_frames_r + 1'b1;
    cr_inc = (close_run_r == CLOSE_RUN_MAX) ? close_run_r : close_run_r + 2'd1;
    dur    = now_seconds - start_r;  // wraps mod 2^32
    yf_sum = {1'b0, yawn_frames_r} + {1'b0, open_run_r};

    if (last_open_r != mouth_open) begin
      if (mouth_open) begin
        if (close_run_r == 2'd0) begin
          start_nxt    = now_seconds;
          open_run_nxt = (open_run_r == CNT_MAX) ? CNT_MAX : open_run_r + 1'b1;
        end else begin
          close_run_nxt = 2'd0;  // brief close forgiven, frame not counted
        end
      end else begin
        close_run_nxt = cr_inc;
      end
      last_open_nxt = mouth_open;
    end else if (mouth_open) begin
      open_run_nxt = (open_run_r == CNT_MAX) ? CNT_MAX : open_run_r + 1'b1;
    end else if (close_run_r != 2'd0) begin
      close_run_nxt = cr_inc;
      if (cr_inc >= END_CNT) begin
        if (dur > TIME_W'(cfg.yawn_min_seconds)) begin
          yawn_frames_nxt = yf_sum[CW] ? CNT_MAX : yf_sum[CW-1:0];
          yawn_total_nxt  = (yawn_total_r == CNT_MAX) ? CNT_MAX : yawn_total_r + 1'b1;
          yawn            = 1'b1;
        end
        open_run_nxt  = '0;
        close_run_nxt = 2'd0;
      end
    end

    shown_cnt      = yawn_total_nxt;
    win_frames_nxt = wf_inc;

    if (window_end) begin
      lhs = PW'({yawn_frames_nxt, {FRAC_W{1'b0}}});
      rhs = PW'(cfg.rate_threshold) * PW'(wf_inc);
      fatigue         = (wf_inc != '0) && (lhs > rhs);
      win_frames_nxt  = '0;
      yawn_frames_nxt = '0;
      yawn_total_nxt  = '0;
    end
  end

  generate
    if (CW >= SHOWN_W) begin : g_shown_trunc
      assign shown = shown_cnt[SHOWN_W-1:0];
    end else begin : g_shown_ext
      assign shown = {{(SHOWN_W-CW){1'b0}}, shown_cnt};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_open_r   <= 1'b0;
      close_run_r   <= 2'd0;
      open_run_r    <= '0;
      start_r       <= '0;
      yawn_frames_r <= '0;
      yawn_total_r  <= '0;
      win_frames_r  <= '0;
    end else if (fire) begin
      last_open_r   <= last_open_nxt;
      close_run_r   <= close_run_nxt;
      open_run_r    <= open_run_nxt;
      start_r       <= start_nxt;
      yawn_frames_r <= yawn_frames_nxt;
      yawn_total_r  <= yawn_total_nxt;
      win_frames_r  <= win_frames_nxt;
    end
  end

  assign res.yawn_event      = yawn;
  assign res.fatigue         = fatigue;
  assign res.window_done     = window_end;
  assign res.yawns_in_window = shown;

`ifndef SYNTHESIS
  // a run always ends before the close counter reaches the end count
  a_close_below_end: assert property (@(posedge clk) disable iff (!rst_n)
    close_run_r < END_CNT)
    else $error("close_run reached end count without ending the run");

  a_yawn_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    fire && yawn |=> open_run_r == '0 && close_run_r == 2'd0)
    else $error("run tracker not cleared after a yawn");

  a_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && window_end |=> win_frames_r == '0 && yawn_frames_r == '0
                           && yawn_total_r == '0)
    else $error("window counters not cleared at window end");

  a_frame_counted: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !window_end |=> win_frames_r != '0)
    else $error("frame not counted in window");

  a_fatigue_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    fatigue |-> window_end)
    else $error("fatigue raised outside window end");
`endif

endmodule

`default_nettype wire

// File: hdl/yawn_episode_detector.sv
// yawn_episode_detector: top level; input register, tracker, result register.
// Depends on yed_pkg, yed_cfg, yed_tracker.
//
//   channel | direction | handshake            | beat carries
//   in_     | in        | in_valid / in_stall   | mouth_open, now_seconds, window_end
//   out_    | out       | out_valid / out_stall | yawn_event, fatigue, window_done,
//           |           |                       |   yawns_in_window
//   cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One result beat per input beat; a beat passes the input register, the tracker update
// and the result register, and an output stall can hold it in the input register. A new
// beat is accepted every cycle while the output is not stalled; the tracker sets that rate.
// Synchronous active-low reset clears all counters and both valid flags.
// Output stall holds the result register and back-pressures the input register.
`default_nettype none

module yawn_episode_detector #(
  parameter int COUNT_BITS       = 16,
  parameter int END_CLOSE_FRAMES = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_mouth_open,
  input  wire logic [yed_pkg::TIME_W-1:0]      in_now_seconds,
  input  wire logic                            in_window_end,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_yawn_event,
  output logic                                 out_fatigue,
  output logic                                 out_window_done,
  output logic [yed_pkg::SHOWN_W-1:0]          out_yawns_in_window,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [yed_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [yed_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import yed_pkg::*;

  yed_cfg_t cfg;
  yed_res_t res;
  yed_res_t res_r;

  logic              in_valid_r, in_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              open_r;
  logic [TIME_W-1:0] now_r;
  logic              wend_r;
  logic              advance;
  logic              fire;
  logic              take;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt  = in_stall ? in_valid_r : in_valid;
    out_valid_nxt = advance ? in_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      open_r <= in_mouth_open;
      now_r  <= in_now_seconds;
      wend_r <= in_window_end;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  yed_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_out   (cfg)
  );

  yed_tracker #(
    .COUNT_BITS       (COUNT_BITS),
    .END_CLOSE_FRAMES (END_CLOSE_FRAMES)
  ) u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .mouth_open  (open_r),
    .now_seconds (now_r),
    .window_end  (wend_r),
    .cfg         (cfg),
    .res         (res)
  );

  assign out_valid           = out_valid_r;
  assign out_yawn_event      = res_r.yawn_event;
  assign out_fatigue         = res_r.fatigue;
  assign out_window_done     = res_r.window_done;
  assign out_yawns_in_window = res_r.yawns_in_window;

endmodule

`default_nettype wire
